/* rtl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg: shared types, codes and microprogram of the text console writer
// Holds the byte codes, the field widths, the control word layout and the
// read-only microprogram that the sequencer steps through.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int COL_FIELD_W = 7;
    localparam int ROW_FIELD_W = 5;

    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [7:0] BLANK_CHAR     = 8'h20;
    localparam logic [7:0] BLANK_COLOR    = 8'h0F;

    typedef logic [4:0] t_op;
    typedef logic [3:0] t_cond;
    typedef logic [4:0] t_step;

    // datapath actions
    localparam t_op OP_NOP         = 5'd0;
    localparam t_op OP_FETCH       = 5'd1;
    localparam t_op OP_CUR_DEC     = 5'd2;
    localparam t_op OP_PHYS_CUR    = 5'd3;
    localparam t_op OP_PHYS_READ   = 5'd4;
    localparam t_op OP_BASE        = 5'd5;
    localparam t_op OP_FILL_WR     = 5'd6;
    localparam t_op OP_SET_VALID   = 5'd7;
    localparam t_op OP_WR_CELL     = 5'd8;
    localparam t_op OP_WR_BS       = 5'd9;
    localparam t_op OP_CR          = 5'd10;
    localparam t_op OP_SCROLL      = 5'd11;
    localparam t_op OP_ROW_INC     = 5'd12;
    localparam t_op OP_CLEAR       = 5'd13;
    localparam t_op OP_RD          = 5'd14;
    localparam t_op OP_RD_CAPTURE  = 5'd15;
    localparam t_op OP_FINISH      = 5'd16;

    // jump conditions
    localparam t_cond C_NEVER        = 4'd0;
    localparam t_cond C_ALWAYS       = 4'd1;
    localparam t_cond C_NO_ACCEPT    = 4'd2;
    localparam t_cond C_IS_CLEAR     = 4'd3;
    localparam t_cond C_IS_READ      = 4'd4;
    localparam t_cond C_NOT_PUT      = 4'd5;
    localparam t_cond C_IS_NL        = 4'd6;
    localparam t_cond C_NOT_BS       = 4'd7;
    localparam t_cond C_X_ZERO       = 4'd8;
    localparam t_cond C_ROW_VALID    = 4'd9;
    localparam t_cond C_FILL_MORE    = 4'd10;
    localparam t_cond C_NO_WRAP      = 4'd11;
    localparam t_cond C_NOT_LAST_ROW = 4'd12;
    localparam t_cond C_IS_BS        = 4'd13;
    localparam t_cond C_READ_OOR     = 4'd14;
    localparam t_cond C_OUT_BUSY     = 4'd15;

    // program labels
    localparam t_step S_FETCH   = 5'd0;
    localparam t_step S_PUT     = 5'd8;
    localparam t_step S_FILL    = 5'd10;
    localparam t_step S_WRITE   = 5'd12;
    localparam t_step S_NEWLINE = 5'd14;
    localparam t_step S_DOWN    = 5'd16;
    localparam t_step S_BS_WR   = 5'd17;
    localparam t_step S_CLEAR   = 5'd18;
    localparam t_step S_READ    = 5'd19;
    localparam t_step S_DONE    = 5'd24;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    typedef struct packed {
        logic is_clear;
        logic is_read;
        logic not_put;
        logic is_nl;
        logic is_bs;
        logic x_zero;
        logic row_valid;
        logic fill_more;
        logic no_wrap;
        logic not_last_row;
        logic read_oor;
    } t_dp_flags;

    typedef struct packed {
        logic [COL_FIELD_W-1:0] cursor_col;
        logic [ROW_FIELD_W-1:0] cursor_row;
        logic [7:0]             cell_char;
        logic [7:0]             cell_color;
        logic                   scrolled;
    } t_result;

    // Jump taken: go to target, else fall through to the next step.
    function automatic t_uword ucode_rom(input t_step step);
        t_uword w;
        case (step)
            5'd0:  w = '{OP_FETCH,      C_NO_ACCEPT,    S_FETCH};
            5'd1:  w = '{OP_NOP,        C_IS_CLEAR,     S_CLEAR};
            5'd2:  w = '{OP_NOP,        C_IS_READ,      S_READ};
            5'd3:  w = '{OP_NOP,        C_NOT_PUT,      S_DONE};
            5'd4:  w = '{OP_NOP,        C_IS_NL,        S_NEWLINE};
            5'd5:  w = '{OP_NOP,        C_NOT_BS,       S_PUT};
            5'd6:  w = '{OP_NOP,        C_X_ZERO,       S_DONE};
            5'd7:  w = '{OP_CUR_DEC,    C_NEVER,        S_FETCH};
            5'd8:  w = '{OP_PHYS_CUR,   C_NEVER,        S_FETCH};
            5'd9:  w = '{OP_BASE,       C_ROW_VALID,    S_WRITE};
            5'd10: w = '{OP_FILL_WR,    C_FILL_MORE,    S_FILL};
            5'd11: w = '{OP_SET_VALID,  C_NEVER,        S_FETCH};
            5'd12: w = '{OP_NOP,        C_IS_BS,        S_BS_WR};
            5'd13: w = '{OP_WR_CELL,    C_NO_WRAP,      S_DONE};
            5'd14: w = '{OP_CR,         C_NOT_LAST_ROW, S_DOWN};
            5'd15: w = '{OP_SCROLL,     C_ALWAYS,       S_DONE};
            5'd16: w = '{OP_ROW_INC,    C_ALWAYS,       S_DONE};
            5'd17: w = '{OP_WR_BS,      C_ALWAYS,       S_DONE};
            5'd18: w = '{OP_CLEAR,      C_ALWAYS,       S_DONE};
            5'd19: w = '{OP_NOP,        C_READ_OOR,     S_DONE};
            5'd20: w = '{OP_PHYS_READ,  C_NEVER,        S_FETCH};
            5'd21: w = '{OP_BASE,       C_NEVER,        S_FETCH};
            5'd22: w = '{OP_RD,         C_NEVER,        S_FETCH};
            5'd23: w = '{OP_RD_CAPTURE, C_NEVER,        S_FETCH};
            5'd24: w = '{OP_FINISH,     C_OUT_BUSY,     S_DONE};
            5'd25: w = '{OP_NOP,        C_ALWAYS,       S_FETCH};
            default: w = '{OP_NOP,      C_ALWAYS,       S_FETCH};
        endcase
        return w;
    endfunction

endpackage

/* rtl/tcw_screen_mem.sv */
// ----------------------------------------------------------------------------
// tcw_screen_mem: screen cell store
// One write port with separate byte enables for character and colour, one
// read port with registered data.
// ----------------------------------------------------------------------------
module tcw_screen_mem #(
    parameter int DEPTH = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS
) (
    input  logic                     i_clk,
    input  logic                     i_we_chr,
    input  logic                     i_we_col,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [7:0]               i_wdata_chr,
    input  logic [7:0]               i_wdata_col,
    output logic [7:0]               o_rdata_chr,
    output logic [7:0]               o_rdata_col
);
    import tcw_pkg::*;

    logic [7:0] r_mem_chr [DEPTH];
    logic [7:0] r_mem_col [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we_chr) begin
            r_mem_chr[i_addr] <= i_wdata_chr;
        end
        if (i_we_col) begin
            r_mem_col[i_addr] <= i_wdata_col;
        end
        if (i_re) begin
            o_rdata_chr <= r_mem_chr[i_addr];
            o_rdata_col <= r_mem_col[i_addr];
        end
    end

endmodule

/* rtl/tcw_datapath.sv */
// ----------------------------------------------------------------------------
// tcw_datapath: cursor, row map and cell access of the text console writer
// Executes one microcode action per cycle. Screen rows are mapped through a
// rotating top pointer; a row whose valid bit is clear reads as blank.
// ----------------------------------------------------------------------------
module tcw_datapath #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tcw_pkg::t_op        i_op,
    input  logic                i_accept,
    input  logic [1:0]          i_mode,
    input  logic [7:0]          i_char_code,
    input  logic [7:0]          i_color,
    input  logic [4:0]          i_read_row,
    input  logic [6:0]          i_read_col,
    output tcw_pkg::t_dp_flags  o_flags,
    output tcw_pkg::t_result    o_result
);
    import tcw_pkg::*;

    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int DEPTH = COLUMNS * ROWS;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
    localparam logic [RW:0]   ROWS_V    = (RW + 1)'(ROWS);
    localparam logic [AW-1:0] COLUMNS_A = AW'(COLUMNS);

    // latched item
    logic [1:0]     r_mode;
    logic [7:0]     r_char;
    logic [7:0]     r_color;
    logic [4:0]     r_read_row;
    logic [6:0]     r_read_col;

    // control state
    logic [CW-1:0]   r_cursor_x;
    logic [RW-1:0]   r_cursor_y;
    logic [RW-1:0]   r_top;
    logic [ROWS-1:0] r_row_valid;

    // working registers
    logic [RW-1:0]   r_phys;
    logic [AW-1:0]   r_base;
    logic [CW-1:0]   r_fill;
    logic            r_rd_valid;
    logic            r_scrolled;
    logic [7:0]      r_cell_chr;
    logic [7:0]      r_cell_col;

    logic [RW-1:0]   w_row_sel;
    logic [RW:0]     w_phys_sum;
    logic [RW-1:0]   w_phys;
    logic [CW-1:0]   w_col_sel;
    logic [AW-1:0]   w_addr;
    logic            w_we_chr;
    logic            w_we_col;
    logic [7:0]      w_wdata_chr;
    logic [7:0]      w_wdata_col;
    logic [7:0]      w_rdata_chr;
    logic [7:0]      w_rdata_col;
    logic [RW-1:0]   n_top;

    // physical row = (logical row + top) mod ROWS
    assign w_row_sel  = (i_op == OP_PHYS_READ) ? RW'(r_read_row) : r_cursor_y;
    assign w_phys_sum = {1'b0, w_row_sel} + {1'b0, r_top};
    assign w_phys     = (w_phys_sum >= ROWS_V) ? RW'(w_phys_sum - ROWS_V) : RW'(w_phys_sum);
    assign n_top      = (r_top == LAST_ROW) ? '0 : r_top + 1'b1;

    always_comb begin
        case (i_op)
            OP_FILL_WR: w_col_sel = r_fill;
            OP_RD:      w_col_sel = CW'(r_read_col);
            default:    w_col_sel = r_cursor_x;
        endcase
    end

    assign w_addr      = r_base + AW'(w_col_sel);
    assign w_we_chr    = (i_op == OP_FILL_WR) || (i_op == OP_WR_CELL) || (i_op == OP_WR_BS);
    assign w_we_col    = (i_op == OP_FILL_WR) || (i_op == OP_WR_CELL);
    assign w_wdata_chr = (i_op == OP_WR_CELL) ? r_char : BLANK_CHAR;
    assign w_wdata_col = (i_op == OP_WR_CELL) ? r_color : BLANK_COLOR;

    tcw_screen_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk       (i_clk),
        .i_we_chr    (w_we_chr),
        .i_we_col    (w_we_col),
        .i_re        (i_op == OP_RD),
        .i_addr      (w_addr),
        .i_wdata_chr (w_wdata_chr),
        .i_wdata_col (w_wdata_col),
        .o_rdata_chr (w_rdata_chr),
        .o_rdata_col (w_rdata_col)
    );

    // cursor and row map
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x  <= '0;
            r_cursor_y  <= '0;
            r_top       <= '0;
            r_row_valid <= '0;
        end else begin
            case (i_op)
                OP_CUR_DEC:   r_cursor_x <= r_cursor_x - 1'b1;
                OP_SET_VALID: r_row_valid[r_phys] <= 1'b1;
                OP_WR_CELL:   r_cursor_x <= (r_cursor_x == LAST_COL) ? '0 : r_cursor_x + 1'b1;
                OP_CR:        r_cursor_x <= '0;
                OP_ROW_INC:   r_cursor_y <= r_cursor_y + 1'b1;
                OP_SCROLL: begin
                    // old top row becomes the new bottom row; drop its contents
                    r_top              <= n_top;
                    r_row_valid[r_top] <= 1'b0;
                end
                OP_CLEAR: begin
                    r_cursor_x  <= '0;
                    r_cursor_y  <= '0;
                    r_top       <= '0;
                    r_row_valid <= '0;
                end
                default: ;
            endcase
        end
    end

    // item latch and working registers
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_mode     <= i_mode;
            r_char     <= i_char_code;
            r_color    <= i_color;
            r_read_row <= i_read_row;
            r_read_col <= i_read_col;
            r_scrolled <= 1'b0;
            r_cell_chr <= '0;
            r_cell_col <= '0;
        end
        case (i_op)
            OP_PHYS_CUR, OP_PHYS_READ: r_phys <= w_phys;
            OP_BASE: begin
                r_base <= AW'(r_phys) * COLUMNS_A;
                r_fill <= '0;
            end
            OP_FILL_WR: r_fill <= r_fill + 1'b1;
            OP_SCROLL:  r_scrolled <= 1'b1;
            OP_RD:      r_rd_valid <= r_row_valid[r_phys];
            OP_RD_CAPTURE: begin
                r_cell_chr <= r_rd_valid ? w_rdata_chr : BLANK_CHAR;
                r_cell_col <= r_rd_valid ? w_rdata_col : BLANK_COLOR;
            end
            default: ;
        endcase
    end

    assign o_flags.is_clear     = (r_mode == MODE_CLEAR);
    assign o_flags.is_read      = (r_mode == MODE_READ);
    assign o_flags.not_put      = (r_mode != MODE_PUT);
    assign o_flags.is_nl        = (r_char == CHAR_NEWLINE);
    assign o_flags.is_bs        = (r_char == CHAR_BACKSPACE);
    assign o_flags.x_zero       = (r_cursor_x == '0);
    assign o_flags.row_valid    = r_row_valid[r_phys];
    assign o_flags.fill_more    = (r_fill != LAST_COL);
    assign o_flags.no_wrap      = (r_cursor_x != LAST_COL);
    assign o_flags.not_last_row = (r_cursor_y != LAST_ROW);
    assign o_flags.read_oor     = (32'(r_read_row) >= ROWS) || (32'(r_read_col) >= COLUMNS);

    assign o_result.cursor_col = COL_FIELD_W'(r_cursor_x);
    assign o_result.cursor_row = ROW_FIELD_W'(r_cursor_y);
    assign o_result.cell_char  = r_cell_chr;
    assign o_result.cell_color = r_cell_col;
    assign o_result.scrolled   = r_scrolled;

endmodule

/* rtl/tcw_sequencer.sv */
// ----------------------------------------------------------------------------
// tcw_sequencer: microprogram step counter
// Reads one control word per step from the microprogram, issues its action
// and either jumps to its target or advances to the next step.
// ----------------------------------------------------------------------------
module tcw_sequencer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcw_pkg::t_dp_flags i_flags,
    input  logic               i_accept,
    input  logic               i_out_busy,
    output tcw_pkg::t_op       o_op
);
    import tcw_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword w_word;
    logic   w_take;

    assign w_word = ucode_rom(r_step);
    assign o_op   = w_word.op;

    always_comb begin
        case (w_word.cond)
            C_NEVER:        w_take = 1'b0;
            C_ALWAYS:       w_take = 1'b1;
            C_NO_ACCEPT:    w_take = !i_accept;
            C_IS_CLEAR:     w_take = i_flags.is_clear;
            C_IS_READ:      w_take = i_flags.is_read;
            C_NOT_PUT:      w_take = i_flags.not_put;
            C_IS_NL:        w_take = i_flags.is_nl;
            C_NOT_BS:       w_take = !i_flags.is_bs;
            C_X_ZERO:       w_take = i_flags.x_zero;
            C_ROW_VALID:    w_take = i_flags.row_valid;
            C_FILL_MORE:    w_take = i_flags.fill_more;
            C_NO_WRAP:      w_take = i_flags.no_wrap;
            C_NOT_LAST_ROW: w_take = i_flags.not_last_row;
            C_IS_BS:        w_take = i_flags.is_bs;
            C_READ_OOR:     w_take = i_flags.read_oor;
            C_OUT_BUSY:     w_take = i_out_busy;
            default:        w_take = 1'b0;
        endcase
    end

    assign n_step = w_take ? w_word.target : r_step + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

/* rtl/text_console_writer.sv */
// ----------------------------------------------------------------------------
// text_console_writer: character-cell text console engine
// Screen store of ROWS x COLUMNS character/colour cells with a cursor,
// driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries one word per command: put a
//   character (newline and backspace handled), clear the screen, or read one
//   cell. Output channel o_valid/i_ready returns one result word per command:
//   cursor after the command, read cell bytes, and a scroll flag.
//   Commands run one at a time. A put or backspace on a row not yet written
//   since the last scroll or clear first blanks that row. After a result is
//   loaded, the sequencer passes an idle step and returns to the fetch step,
//   where the next command is taken.
//   Scroll and clear cost no sweep: rows are addressed through a rotating
//   top-row pointer and a valid bit per row, and an invalid row reads as
//   spaces in colour 0x0F. The sequencer's single memory port sets the pace.
//   Reset clears the cursor, row pointer and row valid bits, so the screen
//   reads blank at once and a command is taken straight after.
//   A held result sits in the output register; the next command is accepted
//   meanwhile and runs up to its final step, where it holds until the
//   receiver takes the waiting word.
// ----------------------------------------------------------------------------
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_char_code,
    input  logic [7:0] i_color,
    input  logic [4:0] i_read_row,
    input  logic [6:0] i_read_col,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [6:0] o_cursor_col,
    output logic [4:0] o_cursor_row,
    output logic [7:0] o_cell_char,
    output logic [7:0] o_cell_color,
    output logic       o_scrolled
);
    import tcw_pkg::*;

    t_op       w_op;
    t_dp_flags w_flags;
    t_result   w_result;
    logic      w_accept;
    logic      w_out_busy;
    logic      w_load;

    logic      r_out_valid;
    t_result   r_out;

    // Take a command only at the fetch step of the microprogram, never in reset.
    assign o_ready    = (w_op == OP_FETCH) && i_rst_n;
    assign w_accept   = i_valid && o_ready;

    // Output register busy: a word is held and the receiver is stalling.
    assign w_out_busy = r_out_valid && !i_ready;
    assign w_load     = (w_op == OP_FINISH) && !w_out_busy;

    tcw_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_flags    (w_flags),
        .i_accept   (w_accept),
        .i_out_busy (w_out_busy),
        .o_op       (w_op)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_op),
        .i_accept    (w_accept),
        .i_mode      (i_mode),
        .i_char_code (i_char_code),
        .i_color     (i_color),
        .i_read_row  (i_read_row),
        .i_read_col  (i_read_col),
        .o_flags     (w_flags),
        .o_result    (w_result)
    );

    // Output register: load on the final step, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_cursor_col = r_out.cursor_col;
    assign o_cursor_row = r_out.cursor_row;
    assign o_cell_char  = r_out.cell_char;
    assign o_cell_color = r_out.cell_color;
    assign o_scrolled   = r_out.scrolled;

    // The sequencer leaves the fetch step right after taking a command.
    a_leave_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_ready)
        else $error("sequencer still at fetch after accepting a command");

    // A new result only appears from the final step of the program.
    a_load_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_op == OP_FINISH))
        else $error("result word raised outside the final step");

    // A scroll always leaves the cursor at column zero of the last row.
    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_scrolled) |->
            (o_cursor_col == '0) && (o_cursor_row == ROW_FIELD_W'(ROWS - 1)))
        else $error("scroll result with cursor off the last row start");

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the text console writer
// Drives command words into the console and checks every result word against
// a cycle-free model of the screen store and cursor held in the bench. It
// opens with a short directed pass over the corner cases, then runs random
// text, newline, backspace, read, clear and unused-mode traffic with bursty
// idling on both channels, calming down towards the end.
// ----------------------------------------------------------------------------
module tb_top;
    import tcw_pkg::*;

    localparam int COLUMNS       = DEF_COLUMNS;
    localparam int ROWS          = DEF_ROWS;
    localparam int CELLS         = COLUMNS * ROWS;
    localparam int RANDOM_WORDS  = 1850;
    localparam int CALM_TAIL     = 150;      // last words sent with no idling
    localparam int SETTLE_CYCLES = 150;      // covers a row blank plus a read
    localparam int CYCLE_LIMIT   = 1000000;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] char_code;
        logic [7:0] color;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_cmd;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       o_ready;
    logic [1:0] i_mode      = MODE_PUT;
    logic [7:0] i_char_code = '0;
    logic [7:0] i_color     = '0;
    logic [4:0] i_read_row  = '0;
    logic [6:0] i_read_col  = '0;
    logic       o_valid;
    logic       i_ready     = 1'b0;
    logic [6:0] o_cursor_col;
    logic [4:0] o_cursor_row;
    logic [7:0] o_cell_char;
    logic [7:0] o_cell_color;
    logic       o_scrolled;

    always #2 i_clk = ~i_clk;

    text_console_writer dut (.*);

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_cmd    pending_words[$];     // commands still to be offered
    t_cmd    on_bus;               // command currently held on the input port
    t_result expected_results[$];  // results owed by the console, oldest first
    int      words_total   = 0;
    int      words_taken   = 0;
    int      cycle_count   = 0;
    logic    failed        = 1'b0;
    logic    calm          = 1'b0; // registered, so both sides see the same value
    int      send_gap      = 0;
    int      send_pct      = 10;
    int      take_gap      = 0;
    int      take_pct      = 10;

    // ------------------------------------------------------------------------
    // Screen model: character and colour bytes per cell, plus the cursor.
    // The cursor column may briefly reach COLUMNS before the wrap.
    // ------------------------------------------------------------------------
    logic [7:0] scr_char  [CELLS];
    logic [7:0] scr_color [CELLS];
    int         cur_x;
    int         cur_y;

    // Blank every cell and home the cursor (reset and clear screen alike).
    function automatic void console_clear();
        for (int i = 0; i < CELLS; i++) begin
            scr_char[i]  = BLANK_CHAR;
            scr_color[i] = BLANK_COLOR;
        end
        cur_x = 0;
        cur_y = 0;
    endfunction

    // Advance to column 0 of the next row; scroll up one row when falling off
    // the bottom, blanking the new bottom row. Returns the scroll flag.
    function automatic logic console_line_feed();
        cur_x = 0;
        cur_y++;
        if (cur_y < ROWS)
            return 1'b0;
        for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
            scr_char[i]  = scr_char[i + COLUMNS];
            scr_color[i] = scr_color[i + COLUMNS];
        end
        for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) begin
            scr_char[i]  = BLANK_CHAR;
            scr_color[i] = BLANK_COLOR;
        end
        cur_y = ROWS - 1;
        return 1'b1;
    endfunction

    // Apply one command to the model and return the result word it owes.
    function automatic t_result console_step(input t_cmd c);
        t_result r;
        int      p;
        r = '0;
        case (c.mode)
            MODE_PUT: begin
                if (c.char_code == CHAR_NEWLINE) begin
                    r.scrolled = console_line_feed();
                end else if (c.char_code == CHAR_BACKSPACE) begin
                    // at column 0 nothing moves and nothing is blanked
                    if (cur_x != 0) begin
                        cur_x--;
                        scr_char[cur_y * COLUMNS + cur_x] = BLANK_CHAR;
                    end
                end else begin
                    p = cur_y * COLUMNS + cur_x;
                    scr_char[p]  = c.char_code;
                    scr_color[p] = c.color;
                    cur_x++;
                    if (cur_x >= COLUMNS)
                        r.scrolled = console_line_feed();
                end
            end
            MODE_CLEAR: begin
                console_clear();
            end
            MODE_READ: begin
                // a cell outside the screen reads as zero
                if (c.read_row < ROWS && c.read_col < COLUMNS) begin
                    p = c.read_row * COLUMNS + c.read_col;
                    r.cell_char  = scr_char[p];
                    r.cell_color = scr_color[p];
                end
            end
            default: begin
                // unused mode: nothing changes
            end
        endcase
        r.cursor_col = COL_FIELD_W'(cur_x);
        r.cursor_row = ROW_FIELD_W'(cur_y);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_word(input logic [1:0] mode, input int ch, input int ink,
                              input int row, input int col);
        t_cmd c;
        c.mode      = mode;
        c.char_code = 8'(ch);
        c.color     = 8'(ink);
        c.read_row  = 5'(row);
        c.read_col  = 7'(col);
        pending_words.push_back(c);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            failed = 1'b1;
        end
    endtask

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 8;
            default: return 40;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offer queued command words, hold each until taken, and predict
    // the result of every word at the edge on which it is accepted.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic next_valid;
        next_valid = i_valid;
        if (i_valid && o_ready) begin
            expected_results.push_back(console_step(on_bus));
            words_taken++;
            next_valid = 1'b0;
        end
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else if (!next_valid) begin
            // change the idling regime now and then, including none at all
            if ($urandom_range(0, 199) == 0)
                send_pct = pick_idle_pct();
            if (send_gap > 0) begin
                send_gap--;
            end else if (!calm && $urandom_range(0, 99) < send_pct) begin
                send_gap = $urandom_range(1, 18) - 1;
            end else if (pending_words.size() > 0) begin
                on_bus      = pending_words.pop_front();
                i_mode      <= on_bus.mode;
                i_char_code <= on_bus.char_code;
                i_color     <= on_bus.color;
                i_read_row  <= on_bus.read_row;
                i_read_col  <= on_bus.read_col;
                next_valid  = 1'b1;
            end
        end
        i_valid <= next_valid;
        calm    <= pending_words.size() <= CALM_TAIL;
    end

    // ------------------------------------------------------------------------
    // Monitor: take result words with bursty back-pressure and compare each
    // one field by field with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        logic    next_ready;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result word with nothing expected, actual col %0d row %0d",
                         $time, o_cursor_col, o_cursor_row);
                failed = 1'b1;
            end else begin
                want = expected_results.pop_front();
                check_field("cursor_col", int'(want.cursor_col), int'(o_cursor_col));
                check_field("cursor_row", int'(want.cursor_row), int'(o_cursor_row));
                check_field("cell_char",  int'(want.cell_char),  int'(o_cell_char));
                check_field("cell_color", int'(want.cell_color), int'(o_cell_color));
                check_field("scrolled",   int'(want.scrolled),   int'(o_scrolled));
            end
        end
        if ($urandom_range(0, 199) == 0)
            take_pct = pick_idle_pct();
        if (take_gap > 0) begin
            take_gap--;
            next_ready = 1'b0;
        end else if (!calm && $urandom_range(0, 99) < take_pct) begin
            take_gap   = $urandom_range(1, 18) - 1;
            next_ready = 1'b0;
        end else begin
            next_ready = 1'b1;
        end
        i_ready <= next_ready;
    end

    // Hard stop should the console hang.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: build the stimulus, release reset, drain and report.
    // ------------------------------------------------------------------------
    initial begin
        int         kind;
        int         n;
        int         ink;
        int         target;
        logic [7:0] glyph;

        console_clear();

        // Directed: untouched screen corners, reads off the screen edge
        queue_word(MODE_READ, 0, 0, 0, 0);
        queue_word(MODE_READ, 255, 255, ROWS - 1, COLUMNS - 1);
        queue_word(MODE_READ, 0, 0, 31, 127);
        queue_word(MODE_READ, 0, 0, ROWS, 0);
        queue_word(MODE_READ, 0, 0, 0, COLUMNS);
        // unused mode with every field bit set: ignored
        queue_word(MODE_UNUSED, 255, 255, 31, 127);
        // backspace at column 0: nothing changes
        queue_word(MODE_PUT, int'(CHAR_BACKSPACE), 255, 0, 0);
        // extreme character and colour bytes
        queue_word(MODE_PUT, 0, 0, 0, 0);
        queue_word(MODE_PUT, 255, 255, 31, 127);
        queue_word(MODE_PUT, 'h41, 'h5A, 0, 0);
        // backspace blanks the character but keeps the colour
        queue_word(MODE_PUT, int'(CHAR_BACKSPACE), 0, 0, 0);
        queue_word(MODE_READ, 0, 0, 0, 2);
        queue_word(MODE_READ, 0, 0, 0, 0);
        queue_word(MODE_READ, 0, 0, 0, 1);
        queue_word(MODE_PUT, int'(CHAR_NEWLINE), 0, 0, 0);
        queue_word(MODE_PUT, 'h7E, 'h81, 0, 0);
        queue_word(MODE_READ, 0, 0, 1, 0);
        // clear wipes the store and homes the cursor
        queue_word(MODE_CLEAR, 0, 0, 0, 0);
        queue_word(MODE_READ, 0, 0, 0, 1);
        queue_word(MODE_READ, 0, 0, 1, 0);

        // Random: mostly runs of text broken by newlines and backspaces, so
        // the cursor wraps and the screen scrolls often; reads sample the
        // store; clears stay rare so that scrolling keeps happening.
        target = pending_words.size() + RANDOM_WORDS;
        while (pending_words.size() < target) begin
            kind = $urandom_range(0, 999);
            ink  = $urandom_range(0, 255);
            if (kind < 430) begin
                n = $urandom_range(1, 12);
                repeat (n) begin
                    glyph = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                            8'($urandom_range(32, 126));
                    queue_word(MODE_PUT, int'(glyph), ink, $urandom, $urandom);
                end
            end else if (kind < 470) begin
                // long line: wraps when it runs past the last column, and a wrap on the last row scrolls
                n = $urandom_range(70, 90);
                repeat (n)
                    queue_word(MODE_PUT, $urandom_range(32, 126), ink, $urandom, $urandom);
            end else if (kind < 590) begin
                n = $urandom_range(1, 3);
                repeat (n)
                    queue_word(MODE_PUT, int'(CHAR_NEWLINE), $urandom, $urandom, $urandom);
            end else if (kind < 660) begin
                n = $urandom_range(1, 4);
                repeat (n)
                    queue_word(MODE_PUT, int'(CHAR_BACKSPACE), $urandom, $urandom, $urandom);
            end else if (kind < 880) begin
                queue_word(MODE_READ, $urandom, $urandom,
                           $urandom_range(0, ROWS - 1), $urandom_range(0, COLUMNS - 1));
            end else if (kind < 930) begin
                // any address, on or off the screen
                queue_word(MODE_READ, $urandom, $urandom, $urandom, $urandom);
            end else if (kind < 990) begin
                queue_word(MODE_UNUSED, $urandom, $urandom, $urandom, $urandom);
            end else begin
                queue_word(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom);
            end
        end
        words_total = pending_words.size();

        // Hold reset, then let the traffic run.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_taken < words_total)
            @(posedge i_clk);
        while (expected_results.size() > 0)
            @(posedge i_clk);
        // Linger so that any stray result word is caught.
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (failed)
            $display("tb_top NOT OK");
        else
            $display("tb_top OK");
        $finish;
    end

endmodule
